### rtl/sjf_pkg.sv
`default_nettype none
package sjf_pkg;
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  localparam logic EV_PREEMPT = 1'b0;
  localparam logic EV_FINISH  = 1'b1;

  localparam logic POL_SJF = 1'b0;
  localparam logic POL_SRT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // write table entries from the input transaction
    logic restart;  // begin a clearing pass over statistics
    logic tick_beg; // latch tick-wide state
    logic scan;     // one slot per cycle: arrivals, selection
    logic decide;   // apply selection, report a preemption
    logic accrue;   // one slot per cycle: accrual, run, done check
    logic finish;   // report a preemption and/or completion and wrap up the tick
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic clr_busy;
  } sts_t;
endpackage
`default_nettype wire

### rtl/sjf_ctrl.sv
`default_nettype none
module sjf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic [1:0]    opcode_i,
  input  wire sjf_pkg::sts_t sts_i,
  output sjf_pkg::cmd_t      cmd_o,
  output logic               busy
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_ACCRUE = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_q, state_d;
  logic       go;

  assign go = start && !busy;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (go) begin
          unique case (opcode_i)
            sjf_pkg::OP_LOAD: cmd_o.load = 1'b1;
            sjf_pkg::OP_TICK: begin
              cmd_o.tick_beg = 1'b1;
              state_d = S_SCAN;
            end
            sjf_pkg::OP_RESTART: begin
              cmd_o.restart = 1'b1;
              state_d = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_CLEAR:  if (!sts_i.clr_busy) state_d = S_IDLE;
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = S_ACCRUE;
      end
      S_ACCRUE: begin
        cmd_o.accrue = 1'b1;
        if (sts_i.scan_last) state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Busy also covers the clearing pass that follows reset.
  assign busy = (state_q != S_IDLE) || sts_i.clr_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

### rtl/sjf_dp.sv
`default_nettype none
module sjf_dp #(
  parameter int MAX_JOBS  = 32,
  parameter int TIME_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire sjf_pkg::cmd_t          cmd_i,
  output sjf_pkg::sts_t               sts_o,
  input  wire logic                   cfg_valid_i,
  input  wire logic                   cfg_index_i,
  input  wire logic [5:0]             cfg_data_i,
  input  wire logic [4:0]             slot_i,
  input  wire logic [TIME_BITS-1:0]   arrival_cycle_i,
  input  wire logic [TIME_BITS-1:0]   service_time_i,
  output logic                        result_strobe_o,
  output logic                        event_res_o,
  output logic [4:0]                  job_slot_o,
  output logic [TIME_BITS-1:0]        job_arrival_o,
  output logic [TIME_BITS-1:0]        job_service_o,
  output logic [TIME_BITS-1:0]        began_at_o,
  output logic [TIME_BITS-1:0]        ended_at_o,
  output logic [TIME_BITS-1:0]        turnaround_o,
  output logic [TIME_BITS-1:0]        waited_o,
  output logic [TIME_BITS-1:0]        response_o,
  output logic [TIME_BITS-1:0]        preemptions_o,
  output logic                        all_done_o,
  output logic                        last_o
);
  localparam int SB = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int RB = $clog2(MAX_JOBS + 1);
  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam logic [RB-1:0] IDLE = RB'(MAX_JOBS);
  // Packed statistics word: executed, wait, turnaround, response, dispatch, flags.
  localparam int SW = 5 * TIME_BITS + 3;

  logic              policy_q;
  logic [5:0]        count_q;
  logic [RB-1:0]     n_q;
  logic [TIME_BITS-1:0] cycle_q, switch_q;
  logic [5:0]        done_q;
  logic [RB-1:0]     run_q;
  logic              run_ok_q;
  logic [RB-1:0]     best_q;
  logic [TIME_BITS-1:0] bkey_q;
  logic [RB-1:0]     idx_q;
  logic              clr_q;
  logic [SB-1:0]     clr_idx_q;
  logic              pend_q;   // preemption reported this tick
  logic              fin_q;    // completion seen in accrue pass
  logic              fin2_q;   // completion follows a preemption report
  logic              disp_new_q;
  logic              alldone_acc_q;
  logic [SB-1:0]     fin_slot_q;
  logic [TIME_BITS-1:0] fin_disp_q, fin_turn_q, fin_wait_q, fin_resp_q;

  // Table memory (arrival, service), stats memory.
  logic              tab_we;
  logic [SB-1:0]     tab_wa, tab_ra;
  logic [2*TIME_BITS-1:0] tab_wd, tab_rd;
  logic              st_we;
  logic [SB-1:0]     st_wa, st_ra;
  logic [SW-1:0]     st_wd, st_rd;

  sjf_ram #(.WIDTH(2*TIME_BITS), .DEPTH(MAX_JOBS)) u_tab (
    .clk_i, .we_i(tab_we), .waddr_i(tab_wa), .wdata_i(tab_wd),
    .raddr_i(tab_ra), .rdata_o(tab_rd)
  );
  sjf_ram #(.WIDTH(SW), .DEPTH(MAX_JOBS)) u_st (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd),
    .raddr_i(st_ra), .rdata_o(st_rd)
  );

  // Scans issue a read at idx and use the data in the next cycle (at idx-1).
  // rd_v marks a valid read in flight.
  logic           rd_v_q;
  logic [SB-1:0]  rd_i_q;
  logic           scanning;
  logic           issue;

  assign scanning = cmd_i.scan || cmd_i.accrue;
  assign issue    = scanning && (idx_q < n_q);
  assign sts_o.scan_last = scanning && !issue && !rd_v_q;
  assign sts_o.clr_busy  = clr_q;

  // Fields of the read data.
  logic [TIME_BITS-1:0] r_arr, r_srv, r_exe, r_wai, r_tur, r_rsp, r_dsp;
  logic [2:0] r_flg;
  assign {r_arr, r_srv} = tab_rd;
  assign {r_exe, r_wai, r_tur, r_rsp, r_dsp, r_flg} = st_rd;

  function automatic logic [TIME_BITS-1:0] sinc(input logic [TIME_BITS-1:0] v);
    return (v == TMAX) ? TMAX : v + 1'b1;
  endfunction

  // Scan-pass slot update (arrival marking), and key for selection.
  logic [2:0]           s_flg;
  logic [TIME_BITS-1:0] s_key;
  logic                 s_cand;
  always_comb begin
    s_flg = r_flg;
    if (r_arr == cycle_q) s_flg[0] = 1'b1;
    if (policy_q == sjf_pkg::POL_SJF) s_key = r_srv;
    else s_key = (r_srv > r_exe) ? r_srv - r_exe : '0;
    s_cand = (s_flg[1:0] == 2'b01);
  end

  // Accrue-pass slot update, including dispatch and run.
  logic [TIME_BITS-1:0] a_exe, a_wai, a_tur, a_rsp, a_dsp;
  logic [2:0]           a_flg;
  logic                 a_is_run, a_fin;
  logic [TIME_BITS-1:0] cyc_next;
  assign cyc_next = sinc(cycle_q);
  always_comb begin
    a_exe = r_exe; a_wai = r_wai; a_tur = r_tur; a_rsp = r_rsp;
    a_dsp = r_dsp; a_flg = r_flg;
    a_is_run = (run_q == RB'(rd_i_q));
    // Dispatch happens to the new running slot when it changed this tick.
    if (a_is_run && disp_new_q) begin
      a_dsp = cycle_q;
      if (!a_flg[2]) begin
        a_rsp = a_wai;
        a_flg[2] = 1'b1;
      end
    end
    if (a_flg[1:0] == 2'b01) begin
      a_tur = sinc(a_tur);
      if (!a_is_run) a_wai = sinc(a_wai);
    end
    a_fin = 1'b0;
    if (a_is_run) begin
      a_exe = sinc(a_exe);
      if (a_exe >= r_srv) begin
        a_flg[1] = 1'b1;
        a_fin = 1'b1;
      end
    end
  end

  // Memory ports.
  always_comb begin
    tab_we = cmd_i.load && (32'(slot_i) < 32'(MAX_JOBS));
    tab_wa = SB'(slot_i);
    tab_wd = {arrival_cycle_i, service_time_i};
    tab_ra = issue ? idx_q[SB-1:0] : run_q[SB-1:0];
    st_ra  = tab_ra;
    st_we  = 1'b0;
    st_wa  = rd_i_q;
    st_wd  = {r_exe, r_wai, r_tur, r_rsp, r_dsp, s_flg};
    if (clr_q) begin
      st_we = 1'b1;
      st_wa = clr_idx_q;
      st_wd = '0;
    end else if (rd_v_q && cmd_i.scan) begin
      st_we = 1'b1;
    end else if (rd_v_q && cmd_i.accrue) begin
      st_we = 1'b1;
      st_wd = {a_exe, a_wai, a_tur, a_rsp, a_dsp, a_flg};
    end
  end

  // The running slot's entries are captured as the scan pass reads them, so
  // the preemption report can be registered in decide.
  logic [TIME_BITS-1:0] run_arr_q, run_srv_q, run_dsp_q, run_tur_q, run_wai_q, run_rsp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && rd_v_q && RB'(rd_i_q) == run_q) begin
      run_arr_q <= r_arr; run_srv_q <= r_srv; run_dsp_q <= r_dsp;
      run_tur_q <= r_tur; run_wai_q <= r_wai; run_rsp_q <= r_rsp;
    end
    if (cmd_i.accrue && rd_v_q && a_fin) begin
      fin_slot_q <= rd_i_q; fin_disp_q <= a_dsp; fin_turn_q <= a_tur;
      fin_wait_q <= a_wai; fin_resp_q <= a_rsp;
      run_arr_q <= r_arr; run_srv_q <= r_srv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= 1'b0; count_q <= 6'd1;
      cycle_q <= '0; switch_q <= '0; done_q <= '0;
      run_q <= IDLE; run_ok_q <= 1'b0; best_q <= IDLE; bkey_q <= '0;
      idx_q <= '0; rd_v_q <= 1'b0; rd_i_q <= '0;
      clr_q <= 1'b1; clr_idx_q <= '0; n_q <= '0;
      pend_q <= 1'b0; fin_q <= 1'b0; fin2_q <= 1'b0; disp_new_q <= 1'b0;
      alldone_acc_q <= 1'b1;
      result_strobe_o <= 1'b0; event_res_o <= 1'b0; last_o <= 1'b0;
      all_done_o <= 1'b0; job_slot_o <= '0;
      job_arrival_o <= '0; job_service_o <= '0;
      began_at_o <= '0; ended_at_o <= '0;
      turnaround_o <= '0; waited_o <= '0;
      response_o <= '0; preemptions_o <= '0;
    end else begin
      result_strobe_o <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == sjf_pkg::CFG_POLICY) policy_q <= cfg_data_i[0];
        else count_q <= cfg_data_i;
      end
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (32'(clr_idx_q) == MAX_JOBS - 1) clr_q <= 1'b0;
      end
      if (cmd_i.restart) begin
        clr_q <= 1'b1; clr_idx_q <= '0;
        cycle_q <= '0; run_q <= IDLE; switch_q <= '0; done_q <= '0;
      end
      if (cmd_i.tick_beg) begin
        n_q <= (32'(count_q) > MAX_JOBS) ? RB'(MAX_JOBS) : RB'(count_q);
        idx_q <= '0; best_q <= IDLE; bkey_q <= '0;
        pend_q <= 1'b0; fin_q <= 1'b0; disp_new_q <= 1'b0;
        run_ok_q <= 1'b0;
      end
      if (scanning) begin
        rd_v_q <= issue;
        rd_i_q <= idx_q[SB-1:0];
        if (issue) idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.scan && rd_v_q) begin
        if (RB'(rd_i_q) == run_q) run_ok_q <= !s_flg[1];
        if (s_cand && (best_q == IDLE || s_key < bkey_q)) begin
          best_q <= RB'(rd_i_q);
          bkey_q <= s_key;
        end
      end
      if (cmd_i.decide) begin
        idx_q <= '0;
        alldone_acc_q <= 1'b1;
        if (!(run_q < n_q && run_ok_q)) begin
          // Running slot finished or out of use.
          run_q <= best_q;
          disp_new_q <= (best_q != IDLE);
        end else if (policy_q == sjf_pkg::POL_SRT && best_q != run_q) begin
          switch_q <= sinc(switch_q);
          pend_q <= 1'b1;
          run_q <= best_q;
          disp_new_q <= (best_q != IDLE);
          event_res_o <= sjf_pkg::EV_PREEMPT;
          job_slot_o <= 5'(run_q);
          job_arrival_o <= run_arr_q; job_service_o <= run_srv_q;
          began_at_o <= run_dsp_q; ended_at_o <= cycle_q;
          turnaround_o <= run_tur_q; waited_o <= run_wai_q;
          response_o <= run_rsp_q; preemptions_o <= sinc(switch_q);
        end
      end
      if (cmd_i.accrue && rd_v_q) begin
        if (!a_flg[1]) alldone_acc_q <= 1'b0;
        if (a_fin) fin_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        cycle_q <= cyc_next;
        disp_new_q <= 1'b0;
        if (fin_q) begin
          run_q <= IDLE;
          done_q <= (done_q == 6'd63) ? done_q : done_q + 1'b1;
        end
        // Emit preemption now if any, with completion in the cycle after it; else completion now.
        if (pend_q) begin
          result_strobe_o <= 1'b1;
          last_o <= !fin_q;
          all_done_o <= alldone_acc_q;
          pend_q <= 1'b0;
          fin2_q <= fin_q;
        end else if (fin_q) begin
          fin2_q <= 1'b0;
          result_strobe_o <= 1'b1;
          last_o <= 1'b1;
          all_done_o <= alldone_acc_q;
          event_res_o <= sjf_pkg::EV_FINISH;
          job_slot_o <= 5'(fin_slot_q);
          job_arrival_o <= run_arr_q; job_service_o <= run_srv_q;
          began_at_o <= fin_disp_q; ended_at_o <= cyc_next;
          turnaround_o <= fin_turn_q; waited_o <= fin_wait_q;
          response_o <= fin_resp_q; preemptions_o <= switch_q;
        end
      end
      if (fin2_q) begin
        fin2_q <= 1'b0;
        result_strobe_o <= 1'b1;
        last_o <= 1'b1;
        event_res_o <= sjf_pkg::EV_FINISH;
        job_slot_o <= 5'(fin_slot_q);
        job_arrival_o <= run_arr_q; job_service_o <= run_srv_q;
        began_at_o <= fin_disp_q; ended_at_o <= cycle_q;
        turnaround_o <= fin_turn_q; waited_o <= fin_wait_q;
        response_o <= fin_resp_q; preemptions_o <= switch_q;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/sjf_ram.sv
`default_nettype none
module sjf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]                rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/sjf_srt_job_scheduler.sv
// Channel  | Direction | Handshake          | Payload
// command  | in        | start / busy       | opcode_i, slot_i, arrival_cycle_i, service_time_i
// config   | in        | cfg_valid/cfg_ready| cfg_index_i, cfg_data_i
// result   | out       | result_valid_o     | event_res_o .. last_o
// A load leaves busy low; a restart keeps busy high through its clearing pass.
// A tick keeps busy high through two passes over the statistics memory, one slot
// per cycle over slots 0 to n-1, n being job_count capped at MAX_JOBS.
// Results follow the tick's last busy cycle, one per cycle, so a second result
// can overlap the next accepted command.
// After reset, busy stays high while the statistics clear.
// The receiver cannot stall results.
`default_nettype none
module sjf_srt_job_scheduler #(
  parameter int MAX_JOBS  = 32,
  parameter int TIME_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [4:0]           slot_i,
  input  wire logic [TIME_BITS-1:0] arrival_cycle_i,
  input  wire logic [TIME_BITS-1:0] service_time_i,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [0:0]           cfg_index_i,
  input  wire logic [5:0]           cfg_data_i,
  output logic                      result_valid_o,
  output logic                      event_res_o,
  output logic [4:0]                job_slot_o,
  output logic [TIME_BITS-1:0]      job_arrival_o,
  output logic [TIME_BITS-1:0]      job_service_o,
  output logic [TIME_BITS-1:0]      began_at_o,
  output logic [TIME_BITS-1:0]      ended_at_o,
  output logic [TIME_BITS-1:0]      turnaround_o,
  output logic [TIME_BITS-1:0]      waited_o,
  output logic [TIME_BITS-1:0]      response_o,
  output logic [TIME_BITS-1:0]      preemptions_o,
  output logic                      all_done_o,
  output logic                      last_o
);
  sjf_pkg::cmd_t cmd;
  sjf_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  sjf_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .opcode_i, .sts_i(sts), .cmd_o(cmd), .busy
  );

  sjf_dp #(.MAX_JOBS(MAX_JOBS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_valid_i(cfg_valid && cfg_ready), .cfg_index_i(cfg_index_i[0]),
    .cfg_data_i, .slot_i, .arrival_cycle_i, .service_time_i,
    .result_strobe_o(result_valid_o), .event_res_o, .job_slot_o,
    .job_arrival_o, .job_service_o, .began_at_o, .ended_at_o,
    .turnaround_o, .waited_o, .response_o, .preemptions_o,
    .all_done_o, .last_o
  );
endmodule
`default_nettype wire

### rtl/sjf_checker.sv
`default_nettype none
module sjf_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic busy,
  input wire logic result_valid_o,
  input wire logic last_o,
  input wire logic event_res_o
);
  // A non-final result is always followed at once by the final one.
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o && last_o) else $error("lost result");
  // The first of two results is a preemption.
  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> event_res_o == 1'b0) else $error("bad order");
  // Results appear just after a tick ends or right behind another result.
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy) || $past(result_valid_o)) else $error("spurious result");
endmodule

bind sjf_srt_job_scheduler sjf_checker u_chk (
  .clk_i, .rst_ni, .busy, .result_valid_o, .last_o, .event_res_o
);
`default_nettype wire

### test/sjf_srt_job_scheduler_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module sjf_srt_job_scheduler_tb;

  typedef struct {
    sjf_pkg::opcode_e op;
    logic [4:0]  slot;
    logic [15:0] arr;
    logic [15:0] svc;
  } job_cmd_t;

  typedef struct {
    logic        ev;
    logic [4:0]  slot;
    logic [15:0] arr;
    logic [15:0] svc;
    logic [15:0] began;
    logic [15:0] ended;
    logic [15:0] tat;
    logic [15:0] wt;
    logic [15:0] rsp;
    logic [15:0] pre;
    logic        all_done;
    logic        last;
  } job_event_t;

  localparam int NJOBS = 32;
  localparam int IDLE  = NJOBS;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i = sjf_pkg::OP_NONE;
  logic [4:0]  slot_i = '0;
  logic [15:0] arrival_cycle_i = '0;
  logic [15:0] service_time_i = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index_i = '0;
  logic [5:0]  cfg_data_i = '0;
  logic        result_valid_o, event_res_o, all_done_o, last_o;
  logic [4:0]  job_slot_o;
  logic [15:0] job_arrival_o, job_service_o, began_at_o, ended_at_o;
  logic [15:0] turnaround_o, waited_o, response_o, preemptions_o;

  sjf_srt_job_scheduler dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  job_cmd_t   cmd_q[$];
  job_event_t event_q[$];
  int         errors = 0;

  // Scheduler state as predicted from the accepted transactions.
  logic        pol_m = sjf_pkg::POL_SJF;
  logic [5:0]  count_m = 6'd1;
  logic [15:0] arr_tab[NJOBS], svc_tab[NJOBS];
  logic [15:0] exe_s[NJOBS], wt_s[NJOBS], tat_s[NJOBS], rsp_s[NJOBS], dsp_s[NJOBS];
  bit          arrived[NJOBS], finished[NJOBS], responded[NJOBS];
  logic [15:0] cyc_m, pre_m;
  int          run_m, done_m;

  function automatic logic [15:0] sat16(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void clear_stats();
    for (int i = 0; i < NJOBS; i++) begin
      exe_s[i] = '0; wt_s[i] = '0; tat_s[i] = '0; rsp_s[i] = '0; dsp_s[i] = '0;
      arrived[i] = 0; finished[i] = 0; responded[i] = 0;
    end
    cyc_m = '0; run_m = IDLE; pre_m = '0; done_m = 0;
  endfunction

  function automatic logic [15:0] sel_key(int i);
    if (pol_m == sjf_pkg::POL_SJF) return svc_tab[i];
    return (svc_tab[i] > exe_s[i]) ? svc_tab[i] - exe_s[i] : 16'd0;
  endfunction

  function automatic job_event_t make_event(logic ev, int i, logic [15:0] ended);
    job_event_t e;
    e.ev = ev; e.slot = i[4:0]; e.arr = arr_tab[i]; e.svc = svc_tab[i];
    e.began = dsp_s[i]; e.ended = ended; e.tat = tat_s[i]; e.wt = wt_s[i];
    e.rsp = rsp_s[i]; e.pre = pre_m; e.all_done = 1'b0; e.last = 1'b0;
    return e;
  endfunction

  function automatic void schedule_step(job_cmd_t c);
    job_event_t evs[$];
    int n, best;
    bit keep, all;
    if (c.op == sjf_pkg::OP_LOAD) begin
      arr_tab[c.slot] = c.arr;
      svc_tab[c.slot] = c.svc;
      return;
    end
    if (c.op == sjf_pkg::OP_RESTART) begin
      clear_stats();
      return;
    end
    if (c.op != sjf_pkg::OP_TICK) return;
    n = (count_m > NJOBS) ? NJOBS : count_m;
    for (int i = 0; i < n; i++)
      if (arr_tab[i] == cyc_m) arrived[i] = 1;
    keep = run_m < n && !finished[run_m];
    if (!keep) run_m = IDLE;
    if (!(pol_m == sjf_pkg::POL_SJF && keep)) begin
      best = IDLE;
      for (int i = 0; i < n; i++) begin
        if (!arrived[i] || finished[i]) continue;
        if (best == IDLE || sel_key(i) < sel_key(best)) best = i;
      end
      if (best != run_m) begin
        if (keep) begin
          pre_m = sat16(pre_m);
          evs.push_back(make_event(sjf_pkg::EV_PREEMPT, run_m, cyc_m));
        end
        run_m = best;
        if (best != IDLE) begin
          dsp_s[best] = cyc_m;
          if (!responded[best]) begin
            rsp_s[best] = wt_s[best];
            responded[best] = 1;
          end
        end
      end
    end
    cyc_m = sat16(cyc_m);
    for (int i = 0; i < n; i++) begin
      if (!arrived[i] || finished[i]) continue;
      tat_s[i] = sat16(tat_s[i]);
      if (i != run_m) wt_s[i] = sat16(wt_s[i]);
    end
    if (run_m < n) begin
      exe_s[run_m] = sat16(exe_s[run_m]);
      if (exe_s[run_m] >= svc_tab[run_m]) begin
        finished[run_m] = 1;
        done_m = (done_m >= 63) ? 63 : done_m + 1;
        evs.push_back(make_event(sjf_pkg::EV_FINISH, run_m, cyc_m));
        run_m = IDLE;
      end
    end
    all = 1;
    for (int i = 0; i < n; i++)
      if (!finished[i]) all = 0;
    foreach (evs[k]) begin
      evs[k].all_done = all;
      evs[k].last = (k == evs.size() - 1);
      event_q.push_back(evs[k]);
    end
  endfunction

  // Command driver: bursts of transactions with random gaps between them.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    job_cmd_t c;
    if (start && !busy) begin
      c.op = sjf_pkg::opcode_e'(opcode_i); c.slot = slot_i;
      c.arr = arrival_cycle_i; c.svc = service_time_i;
      schedule_step(c);
    end
    if (cfg_valid && cfg_ready) begin
      if (cfg_index_i == sjf_pkg::CFG_POLICY) pol_m = cfg_data_i[0];
      else count_m = cfg_data_i;
    end
    if (rst_ni && (!start || !busy)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        opcode_i <= c.op; slot_i <= c.slot;
        arrival_cycle_i <= c.arr; service_time_i <= c.svc;
        start <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    job_event_t e;
    if (rst_ni && result_valid_o) begin
      if (event_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual slot %0d",
                 $time, job_slot_o);
        errors++;
      end else begin
        e = event_q.pop_front();
        check_field("event_res", 16'(e.ev), 16'(event_res_o));
        check_field("job_slot", 16'(e.slot), 16'(job_slot_o));
        check_field("job_arrival", e.arr, job_arrival_o);
        check_field("job_service", e.svc, job_service_o);
        check_field("began_at", e.began, began_at_o);
        check_field("ended_at", e.ended, ended_at_o);
        check_field("turnaround", e.tat, turnaround_o);
        check_field("waited", e.wt, waited_o);
        check_field("response", e.rsp, response_o);
        check_field("preemptions", e.pre, preemptions_o);
        check_field("all_done", 16'(e.all_done), 16'(all_done_o));
        check_field("last", 16'(e.last), 16'(last_o));
      end
    end
  end

  function automatic void push_cmd(sjf_pkg::opcode_e op, int slot, int arr, int svc);
    job_cmd_t c;
    c.op = op; c.slot = slot[4:0]; c.arr = arr[15:0]; c.svc = svc[15:0];
    cmd_q.push_back(c);
  endfunction

  task automatic write_reg(logic [0:0] idx, logic [5:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1; cfg_index_i <= idx; cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // The last transaction may still be starting as the queues drain, so wait
  // past a full tick before going on.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (cmd_q.size() != 0 || start || busy || event_q.size() != 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic gen_phase(bit restart_first, int cnt);
    int nn, r;
    if (restart_first) push_cmd(sjf_pkg::OP_RESTART, 0, 0, 0);
    nn = (cnt > NJOBS) ? NJOBS : cnt;
    for (int s = 0; s < nn; s++)
      push_cmd(sjf_pkg::OP_LOAD, s, $urandom_range(0, 20),
               ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12));
    repeat ($urandom_range(65, 125)) begin
      r = $urandom_range(0, 99);
      if (r < 86) push_cmd(sjf_pkg::OP_TICK, $urandom, $urandom, $urandom);
      else if (r < 90) push_cmd(sjf_pkg::OP_NONE, $urandom, $urandom, $urandom);
      else if (r < 95)
        push_cmd(sjf_pkg::OP_LOAD, $urandom_range(0, 31), $urandom_range(0, 30),
                 $urandom_range(0, 12));
      else if (r < 98) push_cmd(sjf_pkg::OP_LOAD, $urandom, $urandom, $urandom);
      else push_cmd(sjf_pkg::OP_RESTART, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    bit   pol_list[12] = '{0, 1, 0, 1, 1, 0, 1, 0, 1, 0, 1, 0};
    int   cnt_list[12] = '{1, 32, 32, 6, 2, 63, 0, 9, 4, 17, 3, 32};
    bit   rst_list[12] = '{1, 1, 1, 1, 0, 1, 1, 1, 0, 1, 1, 1};
    clear_stats();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Every slot gets loaded first so that no tick ever reads an empty entry.
    push_cmd(sjf_pkg::OP_LOAD, 0, 0, 0);
    for (int s = 1; s < 31; s++) push_cmd(sjf_pkg::OP_LOAD, s, $urandom, $urandom);
    push_cmd(sjf_pkg::OP_LOAD, 31, 16'hFFFF, 16'hFFFF);
    push_cmd(sjf_pkg::OP_TICK, 0, 0, 0);
    push_cmd(sjf_pkg::OP_NONE, 31, 16'hFFFF, 16'hFFFF);
    push_cmd(sjf_pkg::OP_TICK, 31, 16'hFFFF, 16'hFFFF);
    push_cmd(sjf_pkg::OP_RESTART, 0, 0, 0);
    push_cmd(sjf_pkg::OP_TICK, 0, 0, 0);
    push_cmd(sjf_pkg::OP_TICK, 0, 0, 0);
    wait_idle();
    for (int p = 0; p < 12; p++) begin
      write_reg(sjf_pkg::CFG_POLICY, {5'd0, pol_list[p]});
      write_reg(sjf_pkg::CFG_COUNT, cnt_list[p][5:0]);
      gen_phase(rst_list[p], cnt_list[p]);
      wait_idle();
    end
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
rtl/sjf_pkg.sv
rtl/sjf_ctrl.sv
rtl/sjf_dp.sv
rtl/sjf_ram.sv
rtl/sjf_srt_job_scheduler.sv
rtl/sjf_checker.sv
test/sjf_srt_job_scheduler_tb.sv
